// ===== hw/rtl/periodic_timer_bank_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Shared property shorthands for the checker of the timer bank.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define PTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer bank property failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define PTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer bank property failed");

`endif

// ===== hw/rtl/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Request and response types, action codes and cell interface structs.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 32;
  localparam int DEF_NUM_SLOTS = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_REG   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] delay;
  } in_req_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_out;
    logic              ok;
    logic              last;
  } out_rsp_t;

  // Controls from the sequencer to one cell.
  typedef struct packed {
    logic go;      // inject the walk token (first cell only)
    logic step;    // walk advances this cycle
    logic tok_in;  // token from the preceding cell
    logic ld;      // register: load period and delay, deactivate
    logic start;   // load countdown from delay and activate
    logic stop;    // deactivate
  } cell_cmd_t;

  // Status from one cell back to the sequencer and the next cell.
  typedef struct packed {
    logic tok;
    logic fire;
    logic active;
  } cell_sts_t;

endpackage

// ===== hw/rtl/ptb_cell.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank cell
// One timer slot: stored period and delay, countdown and active flag.
// ----------------------------------------------------------------------------
module ptb_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptb_pkg::cell_cmd_t             cmd_i,
  input  logic [ptb_pkg::TIME_W-1:0]     period_i,
  input  logic [ptb_pkg::TIME_W-1:0]     delay_i,
  output ptb_pkg::cell_sts_t             sts_o
);
  import ptb_pkg::*;

  logic              tok_r, tok_nxt;
  logic              act_r, act_nxt;
  logic [TIME_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] per_r;
  logic [TIME_W-1:0] dly_r;
  logic              zero;

  assign zero = (cnt_r == '0);

  always_comb begin
    tok_nxt = tok_r;
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (cmd_i.go) begin
      tok_nxt = 1'b1;
    end else if (cmd_i.step) begin
      tok_nxt = cmd_i.tok_in;
    end
    if (cmd_i.ld || cmd_i.stop) begin
      act_nxt = 1'b0;
    end else if (cmd_i.start) begin
      act_nxt = 1'b1;
      cnt_nxt = dly_r;
    end else if (tok_r && cmd_i.step && act_r) begin
      if (!zero) begin
        cnt_nxt = cnt_r - 1'b1;
      end else if (per_r == '0) begin
        act_nxt = 1'b0;
      end else begin
        cnt_nxt = per_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      act_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (cmd_i.ld) begin
      per_r <= period_i;
      dly_r <= delay_i;
    end
  end

  assign sts_o.tok    = tok_r;
  assign sts_o.fire   = tok_r && act_r && zero;
  assign sts_o.active = act_r;

endmodule

// ===== hw/rtl/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank
// A row of timer cells driven by register, start, stop and tick requests.
// ----------------------------------------------------------------------------
// Register, start and stop requests each return one reply, which lands in the
// output register on the next edge. A tick request passes a token down the
// row of cells, one cell per cycle while the output does not stall the walk;
// new requests are refused until the tick has finished and the block is idle
// again. Each cell counts down only while it holds the token. Expiries come
// out in slot order; the last one of a tick carries last, and a tick with no
// expiry returns nothing.
module periodic_timer_bank #(
  parameter int NUM_SLOTS = ptb_pkg::DEF_NUM_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptb_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output ptb_pkg::out_rsp_t out_rsp
);
  import ptb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_slot_r;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  cell_cmd_t cmd [NUM_SLOTS];
  cell_sts_t sts [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_vec;
  logic                 fire_any;

  logic             in_acc, out_free;
  logic             go_tick, do_reg, do_start, do_stop;
  logic             bank_full, reg_refused, registered;
  logic [IDX_W-1:0] req_idx, reg_idx;
  logic             step, stall, pos_last;
  logic             walk_push, flush_push;
  out_rsp_t         reply;

  // The output register frees up in the same cycle that its response leaves.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign req_idx     = IDX_W'(in_req.slot);
  assign reg_idx     = IDX_W'(used_r);
  assign bank_full   = (used_r == CNT_W'(NUM_SLOTS));
  assign reg_refused = bank_full || ((in_req.period == '0) && (in_req.delay == '0));
  // A slot number below the fill count is always inside the bank.
  assign registered  = (8'(in_req.slot) < 8'(used_r));

  assign go_tick  = in_acc && (in_req.action == ACT_TICK);
  assign do_reg   = in_acc && (in_req.action == ACT_REG) && !reg_refused;
  assign do_start = in_acc && (in_req.action == ACT_START) && registered &&
                    !act_vec[req_idx];
  assign do_stop  = in_acc && (in_req.action == ACT_STOP) && registered;

  // The walk stalls only when a second expiry turns up while the held one
  // cannot move into the output register.
  assign stall    = fire_any && pend_v_r && !out_free;
  assign step     = (state_r == ST_WALK) && !stall;
  assign pos_last = (pos_r == IDX_W'(NUM_SLOTS - 1));

  assign walk_push  = step && fire_any && pend_v_r;
  assign flush_push = (state_r == ST_FLUSH) && pend_v_r && out_free;

  // Row of cells. The token enters the first cell on a tick and moves one
  // cell onward with every walk step.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cmd[i].go     = go_tick;
      assign cmd[i].tok_in = 1'b0;
    end else begin : g_body
      assign cmd[i].go     = 1'b0;
      assign cmd[i].tok_in = sts[i-1].tok;
    end
    assign cmd[i].step  = step;
    assign cmd[i].ld    = do_reg && (reg_idx == IDX_W'(i));
    assign cmd[i].start = do_start && (req_idx == IDX_W'(i));
    assign cmd[i].stop  = do_stop && (req_idx == IDX_W'(i));
    assign act_vec[i]   = sts[i].active;

    ptb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd_i    (cmd[i]),
      .period_i (in_req.period),
      .delay_i  (in_req.delay),
      .sts_o    (sts[i])
    );
  end

  // Only the cell holding the token can fire, so an OR finds it.
  always_comb begin
    fire_any = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      fire_any = fire_any | sts[i].fire;
    end
  end

  // Reply to a register, start or stop request.
  always_comb begin
    reply.kind     = KIND_REPLY;
    reply.slot_out = in_req.slot;
    reply.ok       = 1'b0;
    reply.last     = 1'b1;
    case (in_req.action)
      ACT_REG: begin
        reply.ok       = !reg_refused;
        reply.slot_out = reg_refused ? '0 : SLOT_W'(used_r);
      end
      ACT_START: begin
        reply.ok = do_start;
      end
      ACT_STOP: begin
        reply.ok = registered;
      end
      default: begin
        reply.ok = 1'b0;
      end
    endcase
  end

  // Sequencer and output register. An expiry is held back until the next one
  // turns up or the walk ends, so that the final one of a tick can be marked last.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    pos_nxt       = pos_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;

    if (do_reg) begin
      used_nxt = used_r + 1'b1;
    end

    if (in_acc && (in_req.action != ACT_TICK)) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = reply;
    end

    if (walk_push || flush_push) begin
      out_valid_nxt        = 1'b1;
      out_rsp_nxt.kind     = KIND_EXPIRY;
      out_rsp_nxt.slot_out = SLOT_W'(pend_slot_r);
      out_rsp_nxt.ok       = 1'b1;
      out_rsp_nxt.last     = flush_push;
    end

    case (state_r)
      ST_IDLE: begin
        if (go_tick) begin
          state_nxt = ST_WALK;
          pos_nxt   = '0;
        end
      end
      ST_WALK: begin
        if (step) begin
          pos_nxt = pos_r + 1'b1;
          if (fire_any) begin
            pend_v_nxt = 1'b1;
          end
          if (pos_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_push) begin
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      pos_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pos_r       <= pos_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (step && fire_any) begin
      pend_slot_r <= pos_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== hw/rtl/ptb_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank checker
// Port-level properties of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_timer_bank_macros.svh"

module ptb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ptb_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input ptb_pkg::out_rsp_t out_rsp
);
  import ptb_pkg::*;

  logic reply_req;
  logic reply_out;

  // A register, start or stop request taken at this edge.
  assign reply_req = in_valid && in_ready && (in_req.action != ACT_TICK);
  // A reply presented on the response channel.
  assign reply_out = out_valid && (out_rsp.kind == KIND_REPLY);

  `PTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PTB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_rsp))
  `PTB_ASSERT_NOW(a_expiry_ok, out_valid && (out_rsp.kind == KIND_EXPIRY), out_rsp.ok)
  `PTB_ASSERT_NOW(a_reply_last, reply_out, out_rsp.last)
  `PTB_ASSERT_NEXT(a_reply_next, reply_req, reply_out)

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
